/* rtl/bgf_pkg.sv */
// Package for the battery gauge filter: constants, types and curve tables.
package bgf_pkg;

    localparam int OVERSAMPLE = 8;

    localparam int ADC_W   = 12;
    localparam int MV_W    = 16;
    localparam int PCT_W   = 7;
    localparam int Q8_W    = 24;
    localparam int SUM_W   = ADC_W + $clog2(OVERSAMPLE);
    localparam int CNT_W   = $clog2(OVERSAMPLE + 1);
    localparam int PROD_W  = SUM_W + MV_W;
    localparam int ALPHA_W = 14;
    localparam int FPROD_W = Q8_W + ALPHA_W;
    localparam int SEG_W   = 17;
    localparam int NUM_W   = SEG_W + 4;
    localparam int IDX_W   = 4;

    // The divider serves the curve interpolation.
    localparam int DIV_N_W = NUM_W;
    localparam int DIV_D_W = SEG_W;
    localparam int DIV_C_W = $clog2(DIV_N_W + 1);

    // Group average and Q4.12 to Q16.8 scaling in one constant divide.
    localparam int SCALE_DIV = OVERSAMPLE * 16;

    localparam logic [ALPHA_W-1:0] ALPHA_Q16 = ALPHA_W'(13107);
    localparam logic [FPROD_W:0]   ROUND_UP  = (FPROD_W + 1)'(65535);
    localparam logic [PCT_W-1:0]   PCT_FULL  = PCT_W'(100);
    localparam logic [IDX_W-1:0]   IDX_LAST  = IDX_W'(10);

    // APB register map
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;
    localparam logic [1:0] REG_SENSOR_FITTED = 2'd0;
    localparam logic [1:0] REG_DIVIDER_RATIO = 2'd1;
    localparam logic [1:0] REG_LOW_THRESHOLD = 2'd2;
    localparam logic [1:0] REG_ARMED_THRESHOLD = 2'd3;

    typedef struct packed {
        logic            sensor_fitted;
        logic [MV_W-1:0] divider_ratio;
        logic [MV_W-1:0] low_threshold_mv;
        logic [MV_W-1:0] armed_threshold_mv;
    } cfg_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quotient;
    } div_rsp_t;

    // Discharge curve point idx in Q16.8 millivolts
    function automatic logic [Q8_W-1:0] soc_point(input logic [IDX_W-1:0] idx);
        logic [MV_W-1:0] mv;
        unique case (idx)
            4'd0:    mv = 16'd3270;
            4'd1:    mv = 16'd3610;
            4'd2:    mv = 16'd3690;
            4'd3:    mv = 16'd3710;
            4'd4:    mv = 16'd3730;
            4'd5:    mv = 16'd3750;
            4'd6:    mv = 16'd3770;
            4'd7:    mv = 16'd3790;
            4'd8:    mv = 16'd3830;
            4'd9:    mv = 16'd3870;
            default: mv = 16'd4200;
        endcase
        return {mv, 8'h00};
    endfunction

    // Percent at the lower end of segment idx (idx counts from 1)
    function automatic logic [PCT_W-1:0] pct_base(input logic [IDX_W-1:0] idx);
        logic [PCT_W-1:0] seg;
        seg = PCT_W'(idx) - PCT_W'(1);
        return PCT_W'((seg << 3) + (seg << 1));
    endfunction

endpackage

/* rtl/bgf_if.sv */
// Valid/ready channel interfaces for ADC readings and gauge results.
interface bgf_in_if;
    logic                     valid;
    logic                     ready;
    logic [bgf_pkg::ADC_W-1:0] adc_mv;

    modport source (output valid, output adc_mv, input ready);
    modport sink   (input valid, input adc_mv, output ready);
endinterface

interface bgf_out_if;
    logic                      valid;
    logic                      ready;
    logic [bgf_pkg::MV_W-1:0]  cell_mv;
    logic [bgf_pkg::PCT_W-1:0] charge_percent;
    logic                      battery_low;
    logic                      cutoff_armed;
    logic                      reading_valid;

    modport source (output valid, output cell_mv, output charge_percent,
                    output battery_low, output cutoff_armed, output reading_valid,
                    input ready);
    modport sink   (input valid, input cell_mv, input charge_percent,
                    input battery_low, input cutoff_armed, input reading_valid,
                    output ready);
endinterface

/* rtl/bgf_cfg_regs.sv */
// APB configuration registers of the battery gauge filter.
module bgf_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bgf_pkg::APB_AW-1:0]  paddr,
    input  logic [bgf_pkg::APB_DW-1:0]  pwdata,
    output logic [bgf_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output bgf_pkg::cfg_t               cfg
);
    import bgf_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sensor_fitted      <= 1'b1;
            cfg_reg.divider_ratio      <= 16'd8192;
            cfg_reg.low_threshold_mv   <= 16'd3500;
            cfg_reg.armed_threshold_mv <= 16'd3000;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_SENSOR_FITTED:   cfg_reg.sensor_fitted      <= pwdata[0];
                REG_DIVIDER_RATIO:   cfg_reg.divider_ratio      <= pwdata[MV_W-1:0];
                REG_LOW_THRESHOLD:   cfg_reg.low_threshold_mv   <= pwdata[MV_W-1:0];
                REG_ARMED_THRESHOLD: cfg_reg.armed_threshold_mv <= pwdata[MV_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SENSOR_FITTED:   prdata = APB_DW'(cfg_reg.sensor_fitted);
            REG_DIVIDER_RATIO:   prdata = APB_DW'(cfg_reg.divider_ratio);
            REG_LOW_THRESHOLD:   prdata = APB_DW'(cfg_reg.low_threshold_mv);
            REG_ARMED_THRESHOLD: prdata = APB_DW'(cfg_reg.armed_threshold_mv);
            default:             prdata = '0;
        endcase
    end

endmodule

/* rtl/bgf_div_unit.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
module bgf_div_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  bgf_pkg::div_req_t req,
    output bgf_pkg::div_rsp_t rsp
);
    import bgf_pkg::*;

    logic               busy_reg;
    logic               done_reg;
    logic [DIV_C_W-1:0] cnt_reg;
    logic [DIV_D_W-1:0] rem_reg;
    logic [DIV_N_W-1:0] quo_reg;
    logic [DIV_D_W-1:0] dsr_reg;

    logic [DIV_D_W:0]   shifted;
    logic               fits;
    logic [DIV_D_W-1:0] rem_next;
    logic [DIV_N_W-1:0] quo_next;

    // Bring down the next dividend bit, subtract when it fits
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DIV_N_W-1]};
        fits     = shifted >= {1'b0, dsr_reg};
        rem_next = fits ? DIV_D_W'(shifted - {1'b0, dsr_reg}) : shifted[DIV_D_W-1:0];
        quo_next = {quo_reg[DIV_N_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dsr_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_C_W'(DIV_N_W);
                rem_reg  <= '0;
                quo_reg  <= req.dividend;
                dsr_reg  <= req.divisor;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg - DIV_C_W'(1);
                if (cnt_reg == DIV_C_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

/* rtl/battery_gauge_filter.sv */
// Battery gauge filter: a reading that leaves its group open is taken back to back with the next.
// A closing reading holds the input off until its result word loads, after the scale and filter
// steps, the curve walk and, between curve points, the interpolation divide on the divider;
// a result word still waiting at the output holds the sequencer longer.
// Sense divider not fitted: a reading is dropped and the input held off until the zero word loads.
// rst_n (async, active low) clears sequencer, sum, filter and output word; registers to defaults.
module battery_gauge_filter (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bgf_pkg::APB_AW-1:0] paddr,
    input  logic [bgf_pkg::APB_DW-1:0] pwdata,
    output logic [bgf_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    bgf_in_if.sink                     sample_in,
    bgf_out_if.source                  result_out
);
    import bgf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,    // take readings, accumulate the group sum
        S_MUL,     // group sum times divider ratio
        S_SCALE,   // average and scale the product, seed or go filter
        S_FMUL,    // difference times alpha
        S_FADD,    // apply the rounded filter step
        S_EDGE,    // clamp below the first and above the last curve point
        S_SEG,     // walk the curve one point a cycle
        S_PDIV,    // launch the interpolation divide
        S_PWAIT,   // wait for the interpolated percent
        S_EMIT     // load the output word
    } state_t;

    cfg_t     cfg;
    div_req_t div_req;
    div_rsp_t div_rsp;

    state_t             state_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [Q8_W-1:0]    filt_reg;
    logic               meas_valid_reg;
    logic               zero_res_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [Q8_W-1:0]    samp_reg;
    logic [FPROD_W-1:0] fprod_reg;
    logic               up_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [SEG_W-1:0]   den_reg;
    logic [PCT_W-1:0]   pct_reg;

    logic               out_valid_reg;
    logic [MV_W-1:0]    out_cell_reg;
    logic [PCT_W-1:0]   out_pct_reg;
    logic               out_low_reg;
    logic               out_armed_reg;
    logic               out_rv_reg;

    logic               accept;
    logic               out_free;
    logic [SUM_W-1:0]   sum_next;
    logic [CNT_W-1:0]   count_next;
    logic [PROD_W-1:0]  scaled_q8;
    logic [Q8_W-1:0]    sample_sat;
    logic [Q8_W-1:0]    diff_f;
    logic [FPROD_W:0]   fprod_rnd;
    logic [Q8_W-1:0]    seg_lo;
    logic [Q8_W-1:0]    seg_hi;
    logic [SEG_W-1:0]   seg_off;
    logic [PCT_W-1:0]   pct_interp;
    logic               is_low;
    logic               is_armed;

    bgf_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bgf_div_unit u_div_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Readings are taken only while the sequencer rests; the output register
    // keeps the last word so a slow consumer holds off readings only while the next word waits to load.
    assign sample_in.ready = (state_reg == S_IDLE);
    assign accept          = sample_in.valid && sample_in.ready;
    assign out_free        = !out_valid_reg || result_out.ready;

    always_comb
    begin
        sum_next   = sum_reg + SUM_W'(sample_in.adc_mv);
        count_next = count_reg + CNT_W'(1);

        // Scaled sample saturates to the Q16.8 range
        scaled_q8  = prod_reg / PROD_W'(SCALE_DIV);
        sample_sat = (|scaled_q8[PROD_W-1:Q8_W]) ? '1 : scaled_q8[Q8_W-1:0];

        diff_f    = (samp_reg >= filt_reg) ? (samp_reg - filt_reg) : (filt_reg - samp_reg);
        // Falling step rounds toward minus infinity: round the magnitude up
        fprod_rnd = {1'b0, fprod_reg} + ROUND_UP;

        seg_lo  = soc_point(idx_reg - IDX_W'(1));
        seg_hi  = soc_point(idx_reg);
        seg_off = SEG_W'(filt_reg - seg_lo);

        pct_interp = pct_base(idx_reg) + PCT_W'(div_rsp.quotient[3:0]);

        is_low   = filt_reg < {cfg.low_threshold_mv, 8'h00};
        is_armed = filt_reg > {cfg.armed_threshold_mv, 8'h00};
    end

    // Divider request for the curve interpolation
    always_comb
    begin
        div_req.start    = (state_reg == S_PDIV);
        div_req.dividend = DIV_N_W'(num_reg);
        div_req.divisor  = den_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            sum_reg        <= '0;
            count_reg      <= '0;
            filt_reg       <= '0;
            meas_valid_reg <= 1'b0;
            zero_res_reg   <= 1'b0;
            prod_reg       <= '0;
            samp_reg       <= '0;
            fprod_reg      <= '0;
            up_reg         <= 1'b0;
            idx_reg        <= '0;
            num_reg        <= '0;
            den_reg        <= '0;
            pct_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_cell_reg   <= '0;
            out_pct_reg    <= '0;
            out_low_reg    <= 1'b0;
            out_armed_reg  <= 1'b0;
            out_rv_reg     <= 1'b0;
        end
        else
        begin
            // Drop the word once taken, unless a new one loads at this edge
            if (out_valid_reg && result_out.ready && (state_reg != S_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (!cfg.sensor_fitted)
                        begin
                            // Drop the reading, report an all-zero word
                            zero_res_reg <= 1'b1;
                            state_reg    <= S_EMIT;
                        end
                        else if (count_next == CNT_W'(OVERSAMPLE))
                        begin
                            sum_reg      <= sum_next;
                            zero_res_reg <= 1'b0;
                            state_reg    <= S_MUL;
                        end
                        else
                        begin
                            sum_reg   <= sum_next;
                            count_reg <= count_next;
                        end
                    end
                end

                S_MUL:
                begin
                    prod_reg  <= PROD_W'(sum_reg) * PROD_W'(cfg.divider_ratio);
                    sum_reg   <= '0;
                    count_reg <= '0;
                    state_reg <= S_SCALE;
                end

                S_SCALE:
                begin
                    if (meas_valid_reg)
                    begin
                        samp_reg  <= sample_sat;
                        state_reg <= S_FMUL;
                    end
                    else
                    begin
                        // First measurement seeds the filter
                        filt_reg       <= sample_sat;
                        meas_valid_reg <= 1'b1;
                        state_reg      <= S_EDGE;
                    end
                end

                S_FMUL:
                begin
                    up_reg    <= samp_reg >= filt_reg;
                    fprod_reg <= FPROD_W'(diff_f) * FPROD_W'(ALPHA_Q16);
                    state_reg <= S_FADD;
                end

                S_FADD:
                begin
                    if (up_reg)
                    begin
                        filt_reg <= filt_reg + Q8_W'(fprod_reg[FPROD_W-1:16]);
                    end
                    else
                    begin
                        filt_reg <= filt_reg - Q8_W'(fprod_rnd[FPROD_W:16]);
                    end
                    state_reg <= S_EDGE;
                end

                S_EDGE:
                begin
                    idx_reg <= IDX_W'(1);
                    if (filt_reg <= soc_point('0))
                    begin
                        pct_reg   <= '0;
                        state_reg <= S_EMIT;
                    end
                    else if (filt_reg >= soc_point(IDX_LAST))
                    begin
                        pct_reg   <= PCT_FULL;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_SEG;
                    end
                end

                S_SEG:
                begin
                    if (filt_reg < seg_hi)
                    begin
                        // Numerator 10*(f - lo), denominator hi - lo
                        num_reg   <= (NUM_W'(seg_off) << 3) + (NUM_W'(seg_off) << 1);
                        den_reg   <= SEG_W'(seg_hi - seg_lo);
                        state_reg <= S_PDIV;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end

                S_PDIV:
                begin
                    state_reg <= S_PWAIT;
                end

                S_PWAIT:
                begin
                    if (div_rsp.done)
                    begin
                        pct_reg   <= pct_interp;
                        state_reg <= S_EMIT;
                    end
                end

                S_EMIT:
                begin
                    // Hold until the output register is free
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_cell_reg  <= zero_res_reg ? '0 : filt_reg[Q8_W-1:8];
                        out_pct_reg   <= zero_res_reg ? '0 : pct_reg;
                        out_low_reg   <= !zero_res_reg && is_low;
                        out_armed_reg <= !zero_res_reg && is_armed;
                        out_rv_reg    <= !zero_res_reg;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_out.valid          = out_valid_reg;
    assign result_out.cell_mv        = out_cell_reg;
    assign result_out.charge_percent = out_pct_reg;
    assign result_out.battery_low    = out_low_reg;
    assign result_out.cutoff_armed   = out_armed_reg;
    assign result_out.reading_valid  = out_rv_reg;

endmodule
